FILE: rtl/sga_pkg.sv
// Shared types, constants and fixed-point helpers for the gradient accumulator.
`default_nettype none
package sga_pkg;

  localparam int FRAC_BITS = 16;
  // Dividend magnitude width: |num| * 2^FRAC_BITS
  localparam int MAG_W     = 32 + FRAC_BITS;
  // Divisor magnitude width: covers den and N << (32 - FRAC_BITS)
  localparam int DIVS_W    = (48 - FRAC_BITS > 32) ? 48 - FRAC_BITS : 32;
  localparam int DSHIFT    = 32 - FRAC_BITS;
  localparam int CNT_W     = $clog2(MAG_W + 1);
  localparam int SAT_W     = 72;
  localparam logic [35:0] FOURPI_Q32 = 36'd53972150818;

  localparam logic [2:0] REG_QUERY_X = 3'd0;
  localparam logic [2:0] REG_QUERY_Y = 3'd1;
  localparam logic [2:0] REG_QUERY_Z = 3'd2;
  localparam logic [2:0] REG_SAMPLES = 3'd3;
  localparam logic [2:0] REG_GUARD   = 3'd4;

  typedef struct packed {
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic signed [31:0] query_z;
    logic [15:0]        sample_count;
    logic [15:0]        guard_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] rad;
    logic signed [31:0] ybas;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
    logic               fin;
  } item_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [MAG_W-1:0]  dvd;
    logic [DIVS_W-1:0] dvs;
  } div_req_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_SQRT, ST_FACT, ST_CHK_R,
    ST_DOT0, ST_DOT1, ST_DOT2, ST_DOT3, ST_COS, ST_CHK_C,
    ST_RR0, ST_RR1, ST_DEN0, ST_DEN1,
    ST_NUM0, ST_NUM1, ST_NUM2, ST_GDIV, ST_GMUL0, ST_GMUL1,
    ST_IN0, ST_IN1, ST_IN2, ST_IN3, ST_IN4, ST_DONE
  } st_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-32:0] hi;
    hi = v[SAT_W-1:31];
    if ((&hi) || (~|hi)) begin
      sat32 = v[31:0];
    end else if (v[SAT_W-1]) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'sh7fff_ffff;
    end
  endfunction

  function automatic logic [31:0] absu32(input logic signed [31:0] v);
    absu32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sga_front.sv
// Front end: takes sample transfers, forms q = s - query and queues the sample.
`default_nettype none
module sga_front (
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  signed [31:0]  in_source_x,
  input  wire  signed [31:0]  in_source_y,
  input  wire  signed [31:0]  in_source_z,
  input  wire  signed [31:0]  in_normal_x,
  input  wire  signed [31:0]  in_normal_y,
  input  wire  signed [31:0]  in_normal_z,
  input  wire  signed [31:0]  in_radiance,
  input  wire  signed [31:0]  in_basis_value,
  input  wire  signed [31:0]  in_basis_grad_x,
  input  wire  signed [31:0]  in_basis_grad_y,
  input  wire  signed [31:0]  in_basis_grad_z,
  input  wire                 in_final_sample,
  input  sga_pkg::cfg_t       cfg,
  input  wire                 q_full,
  output logic                q_push,
  output sga_pkg::item_t      q_item
);
  import sga_pkg::*;

  logic signed [32:0] dx, dy, dz;

  always_comb begin
    dx = 33'(in_source_x) - 33'(cfg.query_x);
    dy = 33'(in_source_y) - 33'(cfg.query_y);
    dz = 33'(in_source_z) - 33'(cfg.query_z);
    q_item.qx   = sat32(SAT_W'(dx));
    q_item.qy   = sat32(SAT_W'(dy));
    q_item.qz   = sat32(SAT_W'(dz));
    q_item.nx   = in_normal_x;
    q_item.ny   = in_normal_y;
    q_item.nz   = in_normal_z;
    q_item.rad  = in_radiance;
    q_item.ybas = in_basis_value;
    q_item.gx   = in_basis_grad_x;
    q_item.gy   = in_basis_grad_y;
    q_item.gz   = in_basis_grad_z;
    q_item.fin  = in_final_sample;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

endmodule
`default_nettype wire

FILE: rtl/sga_fifo.sv
// Two-entry sample queue between the front end and the sequencer.
`default_nettype none
module sga_fifo (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  sga_pkg::item_t  push_item,
  input  wire             pop,
  output sga_pkg::item_t  head_item,
  output logic            full,
  output logic            empty
);
  import sga_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  assign head_item = mem_r[rd_ptr_r];
  assign full      = cnt_r[1];
  assign empty     = (cnt_r == 2'd0);

endmodule
`default_nettype wire

FILE: rtl/sga_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module sga_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  sga_pkg::div_req_t            req,
  output logic                         busy,
  output logic signed [sga_pkg::MAG_W:0] quot
);
  import sga_pkg::*;

  logic [MAG_W-1:0]  a_r;
  logic [DIVS_W-1:0] b_r;
  logic [DIVS_W-1:0] rem_r;
  logic              neg_r;
  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVS_W:0]   trial;
  logic              ge;

  assign trial = {rem_r, a_r[MAG_W-1]};
  assign ge    = (trial >= {1'b0, b_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(MAG_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.dvd;
      b_r   <= req.dvs;
      neg_r <= req.neg;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DIVS_W'(trial - {1'b0, b_r}) : trial[DIVS_W-1:0];
      a_r   <= {a_r[MAG_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = neg_r ? -$signed({1'b0, a_r}) : $signed({1'b0, a_r});

endmodule
`default_nettype wire

FILE: rtl/sga_back.sv
// Sequencer: one shared multiplier, square root and divider steps, accumulators, result register.
`default_nettype none
module sga_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  sga_pkg::cfg_t       cfg,
  input  wire                 q_empty,
  input  sga_pkg::item_t      q_head,
  output logic                q_pop,
  output sga_pkg::div_req_t   div_req,
  input  wire                 div_busy,
  input  wire signed [sga_pkg::MAG_W:0] div_quot,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic signed [31:0]  out_gradient_x,
  output logic signed [31:0]  out_gradient_y,
  output logic signed [31:0]  out_gradient_z
);
  import sga_pkg::*;

  st_t st_r, st_nxt;

  logic signed [31:0] q_r [3];
  logic signed [31:0] n_r [3];
  logic signed [31:0] gy_r [3];
  logic signed [31:0] dom_r [3];
  logic signed [63:0] sum_r [3];
  logic signed [31:0] rad_r, ybas_r;
  logic               fin_r;
  logic [1:0]         c_r;

  logic [63:0]        sq_r, rem_r, res_r, bit_r;
  logic [30:0]        r_r;
  logic signed [31:0] factor_r, cosx_r, rr_r, den_r, g_r, inner_r;
  logic signed [65:0] dacc_r;
  logic signed [63:0] tmp_r;
  logic signed [63:0] prod_r;

  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic               out_valid_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] qm;
  logic signed [31:0] dot_sat, num_sat, quot_sat, den_nxt;
  logic signed [65:0] dot_full, inner_full;
  logic signed [66:0] num_full;
  logic [15:0]        nsamp;
  logic [DIVS_W-1:0]  dsamp;
  logic [63:0]        trial, res_step, sq_tot;
  logic               ge, emit;
  logic signed [64:0] acc_full;
  logic signed [63:0] acc_sat;

  assign qm       = prod_r >>> FRAC_BITS;
  assign dot_full = dacc_r + 66'(qm);
  assign dot_sat  = sat32(SAT_W'(dot_full));
  assign num_full = 67'(tmp_r) + 67'(qm) + (67'(qm) <<< 1);
  assign num_sat  = sat32(SAT_W'(num_full));
  assign inner_full = 66'(tmp_r) + 66'(qm);
  assign quot_sat = sat32(SAT_W'(div_quot));
  assign den_nxt  = sat32(SAT_W'(qm));
  assign nsamp    = (cfg.sample_count == 16'd0) ? 16'd1 : cfg.sample_count;
  assign dsamp    = DIVS_W'(nsamp) << DSHIFT;
  assign sq_tot   = sq_r + 64'(prod_r);

  assign trial    = res_r + bit_r;
  assign ge       = (rem_r >= trial);
  assign res_step = ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);

  assign acc_full = 65'(sum_r[c_r]) + 65'(qm);
  assign acc_sat  = (acc_full[64] != acc_full[63]) ?
                    (acc_full[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : acc_full[63:0];

  assign emit = fin_r & (~out_valid_r | ~out_stall);

  always_comb begin
    st_nxt  = st_r;
    q_pop   = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          st_nxt = ST_SQ0;
        end
      end
      ST_SQ0: begin
        mul_a = q_r[0]; mul_b = q_r[0];
        // solid-angle factor runs on the divider while the square root iterates
        div_req.start = 1'b1;
        div_req.dvd   = MAG_W'(FOURPI_Q32) + MAG_W'(dsamp >> 1);
        div_req.dvs   = dsamp;
        st_nxt = ST_SQ1;
      end
      ST_SQ1: begin mul_a = q_r[1]; mul_b = q_r[1]; st_nxt = ST_SQ2; end
      ST_SQ2: begin mul_a = q_r[2]; mul_b = q_r[2]; st_nxt = ST_SQ3; end
      ST_SQ3: st_nxt = ST_SQRT;
      ST_SQRT: if (bit_r == 64'd1) st_nxt = ST_FACT;
      ST_FACT: if (!div_busy) st_nxt = ST_CHK_R;
      ST_CHK_R: begin
        if (r_r != '0 && r_r >= 31'(cfg.guard_threshold)) st_nxt = ST_DOT0;
        else st_nxt = ST_IN0;
      end
      ST_DOT0: begin mul_a = n_r[0]; mul_b = q_r[0]; st_nxt = ST_DOT1; end
      ST_DOT1: begin mul_a = n_r[1]; mul_b = q_r[1]; st_nxt = ST_DOT2; end
      ST_DOT2: begin mul_a = n_r[2]; mul_b = q_r[2]; st_nxt = ST_DOT3; end
      ST_DOT3: begin
        // cosXi = -(dot * ONE) / r
        div_req.start = 1'b1;
        div_req.neg   = ~dot_sat[31];
        div_req.dvd   = MAG_W'(absu32(dot_sat)) << FRAC_BITS;
        div_req.dvs   = DIVS_W'(r_r);
        st_nxt = ST_COS;
      end
      ST_COS: if (!div_busy) st_nxt = ST_CHK_C;
      ST_CHK_C: begin
        if (cosx_r != '0 && absu32(cosx_r) >= 32'(cfg.guard_threshold)) st_nxt = ST_RR0;
        else st_nxt = ST_IN0;
      end
      ST_RR0: begin mul_a = $signed({1'b0, r_r}); mul_b = $signed({1'b0, r_r}); st_nxt = ST_RR1; end
      ST_RR1: st_nxt = ST_DEN0;
      ST_DEN0: begin mul_a = rr_r; mul_b = cosx_r; st_nxt = ST_DEN1; end
      ST_DEN1: st_nxt = (den_nxt == '0) ? ST_IN0 : ST_NUM0;
      ST_NUM0: begin mul_a = n_r[c_r]; mul_b = $signed({1'b0, r_r}); st_nxt = ST_NUM1; end
      ST_NUM1: begin mul_a = q_r[c_r]; mul_b = cosx_r; st_nxt = ST_NUM2; end
      ST_NUM2: begin
        div_req.start = 1'b1;
        div_req.neg   = num_sat[31] ^ den_r[31];
        div_req.dvd   = MAG_W'(absu32(num_sat)) << FRAC_BITS;
        div_req.dvs   = DIVS_W'(absu32(den_r));
        st_nxt = ST_GDIV;
      end
      ST_GDIV: if (!div_busy) st_nxt = ST_GMUL0;
      ST_GMUL0: begin mul_a = factor_r; mul_b = g_r; st_nxt = ST_GMUL1; end
      ST_GMUL1: st_nxt = (c_r == 2'd2) ? ST_IN0 : ST_NUM0;
      ST_IN0: begin mul_a = dom_r[c_r]; mul_b = ybas_r; st_nxt = ST_IN1; end
      ST_IN1: begin mul_a = factor_r; mul_b = gy_r[c_r]; st_nxt = ST_IN2; end
      ST_IN2: st_nxt = ST_IN3;
      ST_IN3: begin mul_a = rad_r; mul_b = inner_r; st_nxt = ST_IN4; end
      ST_IN4: st_nxt = (c_r == 2'd2) ? ST_DONE : ST_IN0;
      ST_DONE: begin
        if (!fin_r || emit) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_r[0] <= q_head.qx;  q_r[1] <= q_head.qy;  q_r[2] <= q_head.qz;
          n_r[0] <= q_head.nx;  n_r[1] <= q_head.ny;  n_r[2] <= q_head.nz;
          gy_r[0] <= q_head.gx; gy_r[1] <= q_head.gy; gy_r[2] <= q_head.gz;
          rad_r  <= q_head.rad;
          ybas_r <= q_head.ybas;
          fin_r  <= q_head.fin;
        end
        sq_r <= '0;
      end
      ST_SQ1, ST_SQ2: sq_r <= sq_tot;
      ST_SQ3: begin
        rem_r <= sq_tot;
        res_r <= '0;
        bit_r <= 64'd1 << 62;
      end
      ST_SQRT: begin
        if (ge) rem_r <= rem_r - trial;
        res_r <= res_step;
        bit_r <= bit_r >> 2;
        if (bit_r == 64'd1) begin
          r_r <= (res_step > 64'h7fff_ffff) ? '1 : res_step[30:0];
        end
      end
      ST_FACT: begin
        factor_r <= div_quot[31:0];
        dom_r[0] <= '0; dom_r[1] <= '0; dom_r[2] <= '0;
        c_r <= 2'd0;
      end
      ST_DOT1: dacc_r <= 66'(qm);
      ST_DOT2: dacc_r <= dot_full;
      ST_COS: cosx_r <= quot_sat;
      ST_RR1: rr_r <= sat32(SAT_W'(qm));
      ST_DEN1: den_r <= den_nxt;
      ST_NUM1: tmp_r <= qm;
      ST_GDIV: g_r <= quot_sat;
      ST_GMUL1: begin
        dom_r[c_r] <= sat32(SAT_W'(qm));
        c_r <= (c_r == 2'd2) ? 2'd0 : c_r + 2'd1;
      end
      ST_IN1: tmp_r <= qm;
      ST_IN2: inner_r <= sat32(SAT_W'(inner_full));
      ST_IN4: c_r <= (c_r == 2'd2) ? 2'd0 : c_r + 2'd1;
      default: ;
    endcase
  end

  // Accumulators and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r[0]    <= '0;
      sum_r[1]    <= '0;
      sum_r[2]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (st_r == ST_IN4) begin
        sum_r[c_r] <= acc_sat;
      end
      if (st_r == ST_DONE && emit) begin
        out_x_r     <= sat32(SAT_W'(sum_r[0]));
        out_y_r     <= sat32(SAT_W'(sum_r[1]));
        out_z_r     <= sat32(SAT_W'(sum_r[2]));
        out_valid_r <= 1'b1;
        sum_r[0]    <= '0;
        sum_r[1]    <= '0;
        sum_r[2]    <= '0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_gradient_x = out_x_r;
  assign out_gradient_y = out_y_r;
  assign out_gradient_z = out_z_r;

endmodule
`default_nettype wire

FILE: rtl/sh_coeff_gradient_accumulator_top.sv
// Top level: configuration registers, front end, sample queue, divider and sequencer.
//
//   channel   direction  handshake            content
//   in_*      input      in_valid/in_stall    one sample (point, normal, L, Y, grad Y, last)
//   out_*     output     out_valid/out_stall  saturated gradient sum, on the last sample
//   APB       config     psel/penable/pready  query point, sample count, guard threshold
//
// The work per sample is set by the shared radix-2 divider (solid-angle factor, cosXi
// and three gradient quotients) and the 32-step square root; the gradient quotients are
// skipped when the gradient term is guarded to zero.
// The two-entry queue takes samples while the sequencer works; the result register
// holds a sum while the next samples run. Reset clears the accumulators and out_valid.
`default_nettype none
module sh_coeff_gradient_accumulator_top (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  signed [31:0] in_source_x,
  input  wire  signed [31:0] in_source_y,
  input  wire  signed [31:0] in_source_z,
  input  wire  signed [31:0] in_normal_x,
  input  wire  signed [31:0] in_normal_y,
  input  wire  signed [31:0] in_normal_z,
  input  wire  signed [31:0] in_radiance,
  input  wire  signed [31:0] in_basis_value,
  input  wire  signed [31:0] in_basis_grad_x,
  input  wire  signed [31:0] in_basis_grad_y,
  input  wire  signed [31:0] in_basis_grad_z,
  input  wire                in_final_sample,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] out_gradient_x,
  output logic signed [31:0] out_gradient_y,
  output logic signed [31:0] out_gradient_z,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [4:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sga_pkg::*;

  cfg_t                cfg_r;
  logic                push, pop, full, empty;
  item_t               push_item, head_item;
  div_req_t            div_req;
  logic                div_busy;
  logic signed [MAG_W:0] div_quot;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.query_x         <= '0;
      cfg_r.query_y         <= '0;
      cfg_r.query_z         <= '0;
      cfg_r.sample_count    <= 16'd1;
      cfg_r.guard_threshold <= 16'd1;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_QUERY_X: cfg_r.query_x         <= pwdata;
        REG_QUERY_Y: cfg_r.query_y         <= pwdata;
        REG_QUERY_Z: cfg_r.query_z         <= pwdata;
        REG_SAMPLES: cfg_r.sample_count    <= pwdata[15:0];
        REG_GUARD:   cfg_r.guard_threshold <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_QUERY_X: prdata = cfg_r.query_x;
      REG_QUERY_Y: prdata = cfg_r.query_y;
      REG_QUERY_Z: prdata = cfg_r.query_z;
      REG_SAMPLES: prdata = {16'd0, cfg_r.sample_count};
      REG_GUARD:   prdata = {16'd0, cfg_r.guard_threshold};
      default:     prdata = '0;
    endcase
  end

  sga_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_source_x     (in_source_x),
    .in_source_y     (in_source_y),
    .in_source_z     (in_source_z),
    .in_normal_x     (in_normal_x),
    .in_normal_y     (in_normal_y),
    .in_normal_z     (in_normal_z),
    .in_radiance     (in_radiance),
    .in_basis_value  (in_basis_value),
    .in_basis_grad_x (in_basis_grad_x),
    .in_basis_grad_y (in_basis_grad_y),
    .in_basis_grad_z (in_basis_grad_z),
    .in_final_sample (in_final_sample),
    .cfg             (cfg_r),
    .q_full          (full),
    .q_push          (push),
    .q_item          (push_item)
  );

  sga_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .full      (full),
    .empty     (empty)
  );

  sga_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  sga_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (empty),
    .q_head         (head_item),
    .q_pop          (pop),
    .div_req        (div_req),
    .div_busy       (div_busy),
    .div_quot       (div_quot),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_gradient_x (out_gradient_x),
    .out_gradient_y (out_gradient_y),
    .out_gradient_z (out_gradient_z)
  );

endmodule
`default_nettype wire
